>>> hdl/dmor_pkg.sv
// Shared types and constants for the forced rolling-mass ODE right-hand side.
// Holds the CORDIC arc table, fixed model constants and pipeline record types.
// Depends on nothing; used by hdl/double_mass_ode_rhs.sv.
package dmor_pkg;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_INERTIA_A   = 3'd0,
		REG_INVERSE_B   = 3'd1,
		REG_INERTIA_J   = 3'd2,
		REG_COUPLING    = 3'd3,
		REG_DRIVE_AMP   = 3'd4,
		REG_TIME_SCALE  = 3'd5,
		REG_GAMMA_MEAN  = 3'd6,
		REG_GAMMA_SWING = 3'd7
	} reg_idx_t;

	// Reset values of the registers.
	localparam logic [30:0] INERTIA_A_RST  = 31'd65536;
	localparam logic [30:0] INVERSE_B_RST  = 31'd65536;
	localparam logic [30:0] INERTIA_J_RST  = 31'd65536;
	localparam logic [30:0] TIME_SCALE_RST = 31'd411775;

	// Fixed model constants: Gamma phase offset (Q0.16 turn), friction (Q16.16).
	localparam logic [15:0] PHASE_OFFSET = 16'd0;
	localparam logic [30:0] FRICTION_1   = 31'd0;
	localparam logic [30:0] FRICTION_2   = 31'd0;
	localparam logic [30:0] FRICTION_3   = 31'd0;

	// CORDIC: start gain in Q2.30 and arctangents in 2^-32 turn.
	localparam int unsigned CORDIC_STEPS = 16;
	localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
	localparam logic [31:0] ARC_TABLE [CORDIC_STEPS] = '{
		32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335086,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41721,     32'd20860
	};

	// Quotient bits produced by the divider, one per stage.
	localparam int unsigned QUOT_BITS = 33;

	typedef logic signed [65:0] wide_t;

	// One CORDIC rotator state.
	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [33:0] z;
		logic               flip;
	} cord_t;

	// Momenta travelling beside the CORDIC stages.
	typedef struct packed {
		logic signed [31:0] p1;
		logic signed [31:0] p2;
		logic signed [31:0] m;
	} pay_t;

	// Values travelling beside the divider.
	typedef struct packed {
		logic signed [31:0] p1;
		logic signed [31:0] p2;
		logic signed [31:0] g;
		logic signed [31:0] v2;
		logic signed [17:0] ch;
		logic signed [17:0] sh;
		logic               sing;
		logic               clip;
	} side_t;

	// Two restoring dividers sharing one denominator.
	typedef struct packed {
		logic [63:0] n_v;
		logic [63:0] n_w;
		logic [62:0] dm;
		logic [62:0] r_v;
		logic [62:0] r_w;
		logic [32:0] q_v;
		logic [32:0] q_w;
		logic        ov_v;
		logic        ov_w;
		logic        neg_v;
		logic        neg_w;
	} div_t;

	// A saturated 32-bit value and whether it was clipped.
	typedef struct packed {
		logic               clip;
		logic signed [31:0] v;
	} sat_t;

endpackage

>>> hdl/double_mass_ode_rhs.sv
// Top level of the forced rolling-mass ODE right-hand side pipeline.
// Uses dmor_pkg for types, the CORDIC arc table and fixed model constants.
// Contains the CORDIC, multiplier and divider stages and the output register.

// The block takes one state word per clock cycle while the output is not
// stalled and returns one word of six saturated Q16.16 rates plus the singular
// and saturated flags for each. Every stage is a register stage: three 16-step
// CORDIC rotators take two steps per stage, the divider settles one quotient
// bit per stage over 33 stages, and multiplies are each followed by a register.
// When the output word is not taken, the whole pipeline holds and s_tready
// drops. Configuration writes must be done while no word is in flight.
module double_mass_ode_rhs (
	input  logic         clk,
	input  logic         arst_n,
	// Configuration write port.
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	// Input stream.
	input  logic         s_tvalid,
	output logic         s_tready,
	// time_phase[15:0], momentum_1[47:16], momentum_2[79:48], moment_m[111:80],
	// heading_phase[127:112]
	input  logic [127:0] s_tdata,
	// Output stream.
	output logic         m_tvalid,
	input  logic         m_tready,
	// rate_momentum_1[31:0], rate_momentum_2[63:32], rate_moment[95:64],
	// rate_position_x[127:96], rate_position_y[159:128], rate_heading[191:160]
	output logic [191:0] m_tdata,
	// singular[0], saturated[1]
	output logic [1:0]   m_tuser
);

	localparam int unsigned N_STAGES = 52;
	localparam int unsigned DIV_BASE = 14;

	// ------------------------------------------------------------------
	// Helpers
	// ------------------------------------------------------------------

	// One CORDIC rotation step.
	function automatic dmor_pkg::cord_t cordic_iter(dmor_pkg::cord_t c, logic [3:0] i);
		dmor_pkg::cord_t    n;
		logic signed [33:0] dx;
		logic signed [33:0] dy;
		logic signed [33:0] arc;
		n   = c;
		dx  = c.y >>> i;
		dy  = c.x >>> i;
		arc = $signed({2'b00, dmor_pkg::ARC_TABLE[i]});
		if (!c.z[33]) begin
			n.x = c.x - dx;
			n.y = c.y + dy;
			n.z = c.z - arc;
		end else begin
			n.x = c.x + dx;
			n.y = c.y - dy;
			n.z = c.z + arc;
		end
		return n;
	endfunction

	// Undo the half-turn fold, round Q2.30 to Q1.16 and clamp to one.
	function automatic logic signed [17:0] trig_fin(logic signed [33:0] v, logic flip);
		logic signed [33:0] t;
		logic signed [33:0] r;
		t = flip ? -v : v;
		r = (t + 34'sd8192) >>> 14;
		if (r > 34'sd65536) begin
			r = 34'sd65536;
		end else if (r < -34'sd65536) begin
			r = -34'sd65536;
		end
		return r[17:0];
	endfunction

	// Add half an LSB and floor-shift by 16.
	function automatic dmor_pkg::wide_t rnd16(dmor_pkg::wide_t v);
		return (v + 66'sd32768) >>> 16;
	endfunction

	// Saturate to 32-bit signed.
	function automatic dmor_pkg::sat_t sat32(dmor_pkg::wide_t v);
		dmor_pkg::sat_t s;
		if (v > 66'sd2147483647) begin
			s.clip = 1'b1;
			s.v    = 32'sh7FFFFFFF;
		end else if (v < -66'sd2147483648) begin
			s.clip = 1'b1;
			s.v    = 32'sh80000000;
		end else begin
			s.clip = 1'b0;
			s.v    = v[31:0];
		end
		return s;
	endfunction

	// Signed result of a finished division, saturated. A magnitude above 2^31
	// clips either way; exactly 2^31 fits only when the result is negative.
	function automatic dmor_pkg::sat_t div_fin(logic [32:0] q, logic ov, logic neg);
		dmor_pkg::sat_t s;
		logic           over;
		logic [32:0]    nq;
		over = ov || q[32] || (q[31] && (q[30:0] != 31'd0));
		nq   = -q;
		if (over) begin
			s.clip = 1'b1;
			s.v    = neg ? 32'sh80000000 : 32'sh7FFFFFFF;
		end else if (!neg && q[31]) begin
			s.clip = 1'b1;
			s.v    = 32'sh7FFFFFFF;
		end else begin
			s.clip = 1'b0;
			s.v    = neg ? nq[31:0] : q[31:0];
		end
		return s;
	endfunction

	// One restoring step: returns the quotient bit over the new remainder.
	function automatic logic [63:0] div_bit(logic [62:0] r, logic [62:0] dm, logic b);
		logic [62:0] t;
		t = {r[61:0], b};
		if (t >= dm) begin
			return {1'b1, t - dm};
		end
		return {1'b0, t};
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------

	logic        [30:0] inertia_a_q;
	logic        [30:0] inverse_b_q;
	logic        [30:0] inertia_j_q;
	logic signed [31:0] coupling_q;
	logic signed [31:0] drive_amp_q;
	logic        [30:0] time_scale_q;
	logic signed [31:0] gamma_mean_q;
	logic signed [31:0] gamma_swing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inertia_a_q   <= dmor_pkg::INERTIA_A_RST;
			inverse_b_q   <= dmor_pkg::INVERSE_B_RST;
			inertia_j_q   <= dmor_pkg::INERTIA_J_RST;
			coupling_q    <= '0;
			drive_amp_q   <= '0;
			time_scale_q  <= dmor_pkg::TIME_SCALE_RST;
			gamma_mean_q  <= '0;
			gamma_swing_q <= '0;
		end else if (cfg_we) begin
			case (dmor_pkg::reg_idx_t'(cfg_index))
				dmor_pkg::REG_INERTIA_A:   inertia_a_q   <= cfg_data[30:0];
				dmor_pkg::REG_INVERSE_B:   inverse_b_q   <= cfg_data[30:0];
				dmor_pkg::REG_INERTIA_J:   inertia_j_q   <= cfg_data[30:0];
				dmor_pkg::REG_COUPLING:    coupling_q    <= cfg_data;
				dmor_pkg::REG_DRIVE_AMP:   drive_amp_q   <= cfg_data;
				dmor_pkg::REG_TIME_SCALE:  time_scale_q  <= cfg_data[30:0];
				dmor_pkg::REG_GAMMA_MEAN:  gamma_mean_q  <= cfg_data;
				dmor_pkg::REG_GAMMA_SWING: gamma_swing_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Pipeline control: every stage moves when the output is free or taken
	// ------------------------------------------------------------------

	logic                adv;
	logic [N_STAGES:1]   vld_q;

	assign adv      = !vld_q[N_STAGES] || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[N_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[N_STAGES-1:1], s_tvalid};
		end
	end

	// ------------------------------------------------------------------
	// Stages 1 to 8: three CORDIC rotators, two steps per stage
	// ------------------------------------------------------------------

	logic [15:0]     ph_in [3];
	dmor_pkg::cord_t cord_in [3];
	dmor_pkg::pay_t  pay_in;
	dmor_pkg::cord_t cord_s [1:8][3];
	dmor_pkg::pay_t  pay_s  [1:8];

	// Fold each angle into the right half-turn and load the rotators.
	always_comb begin
		ph_in[0] = s_tdata[15:0];
		ph_in[1] = s_tdata[15:0] + dmor_pkg::PHASE_OFFSET;
		ph_in[2] = s_tdata[127:112];
		for (int u = 0; u < 3; u++) begin
			cord_in[u].flip = ph_in[u][15] ^ ph_in[u][14];
			cord_in[u].x    = dmor_pkg::CORDIC_X0;
			cord_in[u].y    = '0;
			cord_in[u].z    = $signed({{2{ph_in[u][15] ^ cord_in[u].flip}},
				ph_in[u][14:0], 16'd0});
		end
		pay_in.p1 = s_tdata[47:16];
		pay_in.p2 = s_tdata[79:48];
		pay_in.m  = s_tdata[111:80];
	end

	for (genvar g = 0; g < 8; g++) begin : g_cordic
		if (g == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (adv) begin
					for (int u = 0; u < 3; u++) begin
						cord_s[1][u] <= cordic_iter(cordic_iter(cord_in[u], 4'd0), 4'd1);
					end
					pay_s[1] <= pay_in;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (adv) begin
					for (int u = 0; u < 3; u++) begin
						cord_s[g+1][u] <= cordic_iter(cordic_iter(cord_s[g][u],
							4'(2*g)), 4'(2*g+1));
					end
					pay_s[g+1] <= pay_s[g];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 9: finish cos(t), sin(t + offset), cos and sin of heading
	// ------------------------------------------------------------------

	logic signed [17:0] ct_s9, sg_s9, ch_s9, sh_s9;
	dmor_pkg::pay_t     pay_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			ct_s9  <= trig_fin(cord_s[8][0].x, cord_s[8][0].flip);
			sg_s9  <= trig_fin(cord_s[8][1].y, cord_s[8][1].flip);
			ch_s9  <= trig_fin(cord_s[8][2].x, cord_s[8][2].flip);
			sh_s9  <= trig_fin(cord_s[8][2].y, cord_s[8][2].flip);
			pay_s9 <= pay_s[8];
		end
	end

	// ------------------------------------------------------------------
	// Stage 10: products with the cosine, the sine and 1/B
	// ------------------------------------------------------------------

	logic signed [63:0] prod_k_s10, prod_d_s10, prod_g_s10, prod_b_s10;
	logic signed [17:0] ch_s10, sh_s10;
	dmor_pkg::pay_t     pay_s10;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_k_s10 <= coupling_q * ct_s9;
			prod_d_s10 <= drive_amp_q * ct_s9;
			prod_g_s10 <= gamma_swing_q * sg_s9;
			prod_b_s10 <= pay_s9.p2 * $signed({1'b0, inverse_b_q});
			ch_s10     <= ch_s9;
			sh_s10     <= sh_s9;
			pay_s10    <= pay_s9;
		end
	end

	// ------------------------------------------------------------------
	// Stage 11: K, Mt, Gamma and v2, rounded and saturated
	// ------------------------------------------------------------------

	dmor_pkg::sat_t     kc_c, mt_c, g_c, v2_c;
	logic signed [31:0] kc_s11, mt_s11;
	dmor_pkg::side_t    side_s11;

	always_comb begin
		kc_c = sat32(rnd16(dmor_pkg::wide_t'(prod_k_s10)));
		mt_c = sat32(dmor_pkg::wide_t'(pay_s10.m) + rnd16(dmor_pkg::wide_t'(prod_d_s10)));
		g_c  = sat32(dmor_pkg::wide_t'(gamma_mean_q)
			+ rnd16(dmor_pkg::wide_t'(prod_g_s10)));
		v2_c = sat32(rnd16(dmor_pkg::wide_t'(prod_b_s10)));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kc_s11        <= kc_c.v;
			mt_s11        <= mt_c.v;
			side_s11.p1   <= pay_s10.p1;
			side_s11.p2   <= pay_s10.p2;
			side_s11.g    <= g_c.v;
			side_s11.v2   <= v2_c.v;
			side_s11.ch   <= ch_s10;
			side_s11.sh   <= sh_s10;
			side_s11.sing <= 1'b0;
			side_s11.clip <= kc_c.clip | mt_c.clip | g_c.clip | v2_c.clip;
		end
	end

	// ------------------------------------------------------------------
	// Stage 12: products for the denominator and both numerators
	// ------------------------------------------------------------------

	logic signed [63:0] aj_s12, kk_s12, jp_s12, km_s12, am_s12, kp_s12;
	dmor_pkg::side_t    side_s12;

	always_ff @(posedge clk) begin
		if (adv) begin
			aj_s12   <= $signed({1'b0, inertia_a_q}) * $signed({1'b0, inertia_j_q});
			kk_s12   <= kc_s11 * kc_s11;
			jp_s12   <= $signed({1'b0, inertia_j_q}) * side_s11.p1;
			km_s12   <= kc_s11 * mt_s11;
			am_s12   <= $signed({1'b0, inertia_a_q}) * mt_s11;
			kp_s12   <= kc_s11 * side_s11.p1;
			side_s12 <= side_s11;
		end
	end

	// ------------------------------------------------------------------
	// Stage 13: D and the numerators, exact
	// ------------------------------------------------------------------

	logic signed [64:0] d_s13, nv_s13, nw_s13;
	dmor_pkg::side_t    side_c13;
	dmor_pkg::side_t    side_s13;

	// The denominator is zero exactly when A times J equals K squared.
	always_comb begin
		side_c13      = side_s12;
		side_c13.sing = (aj_s12 == kk_s12);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s13    <= {aj_s12[63], aj_s12} - {kk_s12[63], kk_s12};
			nv_s13   <= {jp_s12[63], jp_s12} - {km_s12[63], km_s12};
			nw_s13   <= {am_s12[63], am_s12} - {kp_s12[63], kp_s12};
			side_s13 <= side_c13;
		end
	end

	// ------------------------------------------------------------------
	// Stage 14: magnitudes, signs, early overflow check, first remainder
	// ------------------------------------------------------------------

	dmor_pkg::div_t  dv_s   [0:dmor_pkg::QUOT_BITS];
	dmor_pkg::side_t side_dv [0:dmor_pkg::QUOT_BITS];
	dmor_pkg::div_t  dv_in;
	logic [64:0]     nv_neg, nw_neg, d_neg;

	always_comb begin
		nv_neg      = -nv_s13;
		nw_neg      = -nw_s13;
		d_neg       = -d_s13;
		dv_in.n_v   = nv_s13[64] ? nv_neg[63:0] : nv_s13[63:0];
		dv_in.n_w   = nw_s13[64] ? nw_neg[63:0] : nw_s13[63:0];
		dv_in.dm    = d_s13[64] ? d_neg[62:0] : d_s13[62:0];
		dv_in.neg_v = nv_s13[64] ^ d_s13[64];
		dv_in.neg_w = nw_s13[64] ^ d_s13[64];
		// The quotient reaches 2^33 or more when n / 2^17 is at least D.
		dv_in.ov_v  = {16'd0, dv_in.n_v[63:17]} >= dv_in.dm;
		dv_in.ov_w  = {16'd0, dv_in.n_w[63:17]} >= dv_in.dm;
		// The scaled dividend is n * 2^16; its bits above the quotient start here.
		dv_in.r_v   = {16'd0, dv_in.n_v[63:17]};
		dv_in.r_w   = {16'd0, dv_in.n_w[63:17]};
		dv_in.q_v   = '0;
		dv_in.q_w   = '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s[0]    <= dv_in;
			side_dv[0] <= side_s13;
		end
	end

	// ------------------------------------------------------------------
	// Stages 15 to 47: one quotient bit of each division per stage
	// ------------------------------------------------------------------

	for (genvar i = 1; i <= dmor_pkg::QUOT_BITS; i++) begin : g_div
		localparam int unsigned K  = dmor_pkg::QUOT_BITS - i;
		localparam int unsigned BI = (K >= 16) ? K - 16 : 0;
		logic           bv, bw;
		logic [63:0]    sv, sw;
		dmor_pkg::div_t nx;

		always_comb begin
			bv     = (K >= 16) ? dv_s[i-1].n_v[BI] : 1'b0;
			bw     = (K >= 16) ? dv_s[i-1].n_w[BI] : 1'b0;
			sv     = div_bit(dv_s[i-1].r_v, dv_s[i-1].dm, bv);
			sw     = div_bit(dv_s[i-1].r_w, dv_s[i-1].dm, bw);
			nx     = dv_s[i-1];
			nx.r_v = sv[62:0];
			nx.r_w = sw[62:0];
			nx.q_v = {dv_s[i-1].q_v[31:0], sv[63]};
			nx.q_w = {dv_s[i-1].q_w[31:0], sw[63]};
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[i]    <= nx;
				side_dv[i] <= side_dv[i-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 48: signed, saturated v1 and w
	// ------------------------------------------------------------------

	dmor_pkg::sat_t     v1_c, w_c;
	dmor_pkg::side_t    side_c48;
	logic signed [31:0] v1_s48, w_s48;
	dmor_pkg::side_t    side_s48;

	always_comb begin
		v1_c = div_fin(dv_s[dmor_pkg::QUOT_BITS].q_v, dv_s[dmor_pkg::QUOT_BITS].ov_v,
			dv_s[dmor_pkg::QUOT_BITS].neg_v);
		w_c  = div_fin(dv_s[dmor_pkg::QUOT_BITS].q_w, dv_s[dmor_pkg::QUOT_BITS].ov_w,
			dv_s[dmor_pkg::QUOT_BITS].neg_w);
		side_c48      = side_dv[dmor_pkg::QUOT_BITS];
		side_c48.clip = side_dv[dmor_pkg::QUOT_BITS].clip | v1_c.clip | w_c.clip;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v1_s48   <= v1_c.v;
			w_s48    <= w_c.v;
			side_s48 <= side_c48;
		end
	end

	// ------------------------------------------------------------------
	// Stage 49: products of the bracket terms
	// ------------------------------------------------------------------

	logic signed [63:0] p2w_s49, gv2_s49, f1v1_s49, p1w_s49, gv1_s49, f2v2_s49;
	logic signed [63:0] p1v2_s49, p2v1_s49, f3w_s49, v1ch_s49, v2sh_s49;
	logic signed [63:0] v1sh_s49, v2ch_s49;
	logic signed [31:0] w_s49;
	logic               sing_s49, clip_s49;

	always_ff @(posedge clk) begin
		if (adv) begin
			p2w_s49  <= side_s48.p2 * w_s48;
			gv2_s49  <= side_s48.g * side_s48.v2;
			f1v1_s49 <= $signed({1'b0, dmor_pkg::FRICTION_1}) * v1_s48;
			p1w_s49  <= side_s48.p1 * w_s48;
			gv1_s49  <= side_s48.g * v1_s48;
			f2v2_s49 <= $signed({1'b0, dmor_pkg::FRICTION_2}) * side_s48.v2;
			p1v2_s49 <= side_s48.p1 * side_s48.v2;
			p2v1_s49 <= side_s48.p2 * v1_s48;
			f3w_s49  <= $signed({1'b0, dmor_pkg::FRICTION_3}) * w_s48;
			v1ch_s49 <= v1_s48 * side_s48.ch;
			v2sh_s49 <= side_s48.v2 * side_s48.sh;
			v1sh_s49 <= v1_s48 * side_s48.sh;
			v2ch_s49 <= side_s48.v2 * side_s48.ch;
			w_s49    <= w_s48;
			sing_s49 <= side_s48.sing;
			clip_s49 <= side_s48.clip;
		end
	end

	// ------------------------------------------------------------------
	// Stage 50: the six unscaled rates
	// ------------------------------------------------------------------

	dmor_pkg::sat_t     br_c [5];
	logic signed [31:0] r_s50 [6];
	logic               sing_s50, clip_s50;

	always_comb begin
		br_c[0] = sat32(rnd16(dmor_pkg::wide_t'(p2w_s49)) - rnd16(dmor_pkg::wide_t'(gv2_s49))
			- rnd16(dmor_pkg::wide_t'(f1v1_s49)));
		br_c[1] = sat32(rnd16(dmor_pkg::wide_t'(gv1_s49)) - rnd16(dmor_pkg::wide_t'(p1w_s49))
			- rnd16(dmor_pkg::wide_t'(f2v2_s49)));
		br_c[2] = sat32(rnd16(dmor_pkg::wide_t'(p1v2_s49)) - rnd16(dmor_pkg::wide_t'(p2v1_s49))
			- rnd16(dmor_pkg::wide_t'(f3w_s49)));
		br_c[3] = sat32(rnd16(dmor_pkg::wide_t'(v1ch_s49))
			- rnd16(dmor_pkg::wide_t'(v2sh_s49)));
		br_c[4] = sat32(rnd16(dmor_pkg::wide_t'(v1sh_s49))
			+ rnd16(dmor_pkg::wide_t'(v2ch_s49)));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 5; k++) begin
				r_s50[k] <= br_c[k].v;
			end
			r_s50[5] <= w_s49;
			sing_s50 <= sing_s49;
			clip_s50 <= clip_s49 | br_c[0].clip | br_c[1].clip | br_c[2].clip
				| br_c[3].clip | br_c[4].clip;
		end
	end

	// ------------------------------------------------------------------
	// Stage 51: scale by the time factor
	// ------------------------------------------------------------------

	logic signed [63:0] ks_s51 [6];
	logic               sing_s51, clip_s51;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 6; k++) begin
				ks_s51[k] <= $signed({1'b0, time_scale_q}) * r_s50[k];
			end
			sing_s51 <= sing_s50;
			clip_s51 <= clip_s50;
		end
	end

	// ------------------------------------------------------------------
	// Stage 52: output register
	// ------------------------------------------------------------------

	dmor_pkg::sat_t     out_c [6];
	logic               out_clip;
	logic signed [31:0] out_s52 [6];
	logic               sing_s52, sat_s52;

	always_comb begin
		out_clip = 1'b0;
		for (int k = 0; k < 6; k++) begin
			out_c[k] = sat32(rnd16(dmor_pkg::wide_t'(ks_s51[k])));
			out_clip = out_clip | out_c[k].clip;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 6; k++) begin
				out_s52[k] <= sing_s51 ? 32'sd0 : out_c[k].v;
			end
			sing_s52 <= sing_s51;
			sat_s52  <= !sing_s51 && (clip_s51 || out_clip);
		end
	end

	assign m_tdata = {out_s52[5], out_s52[4], out_s52[3], out_s52[2], out_s52[1], out_s52[0]};
	assign m_tuser = {sat_s52, sing_s52};

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------

	// A singular word carries zero rates and no saturation.
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
		else $error("singular word with nonzero rates or saturation");

	// Without early overflow the final remainders stay below the denominator.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[DIV_BASE + dmor_pkg::QUOT_BITS] && !side_dv[dmor_pkg::QUOT_BITS].sing
		&& !dv_s[dmor_pkg::QUOT_BITS].ov_v && !dv_s[dmor_pkg::QUOT_BITS].ov_w
		|-> (dv_s[dmor_pkg::QUOT_BITS].r_v < dv_s[dmor_pkg::QUOT_BITS].dm)
		&& (dv_s[dmor_pkg::QUOT_BITS].r_w < dv_s[dmor_pkg::QUOT_BITS].dm))
		else $error("divider remainder not below denominator");

	// The cosine of t and the sine of the heading lie within plus and minus one.
	a_trig_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[9] |-> (ct_s9 <= 18'sd65536) && (ct_s9 >= -18'sd65536)
		&& (sh_s9 <= 18'sd65536) && (sh_s9 >= -18'sd65536))
		else $error("trig result out of range");

	// A stall holds the words inside the pipeline.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("pipeline moved during a stall");

endmodule

>>> tb/double_mass_ode_rhs_tb.sv
// Self-checking testbench for double_mass_ode_rhs: a bit-exact predictor of the
// CORDIC, divider and saturation arithmetic checks every output word in order.
// Depends on hdl/dmor_pkg.sv and hdl/double_mass_ode_rhs.sv.
`timescale 1ns / 1ps

module double_mass_ode_rhs_tb;

	typedef logic signed [95:0] wv_t;

	// Limits of a 32-bit signed value.
	localparam wv_t S32_MAX = 96'sd2147483647;
	localparam wv_t S32_MIN = -96'sd2147483648;

	// One expected output word.
	typedef struct {
		logic [31:0] rate [6];
		logic        sing;
		logic        sat;
	} rates_t;

	// Predicts the rates of each accepted state word and checks output words.
	class rhs_scoreboard;
		logic [30:0] inertia_a, inverse_b, inertia_j, time_scale;
		logic signed [31:0] coupling, drive_amp, gamma_mean, gamma_swing;
		rates_t pending [$];
		int errors;
		bit clip;

		function void restore();
			inertia_a = dmor_pkg::INERTIA_A_RST;
			inverse_b = dmor_pkg::INVERSE_B_RST;
			inertia_j = dmor_pkg::INERTIA_J_RST;
			time_scale = dmor_pkg::TIME_SCALE_RST;
			coupling = 0;
			drive_amp = 0;
			gamma_mean = 0;
			gamma_swing = 0;
			errors = 0;
		endfunction

		function void set_reg(dmor_pkg::reg_idx_t idx, logic [31:0] data);
			case (idx)
				dmor_pkg::REG_INERTIA_A:   inertia_a = data[30:0];
				dmor_pkg::REG_INVERSE_B:   inverse_b = data[30:0];
				dmor_pkg::REG_INERTIA_J:   inertia_j = data[30:0];
				dmor_pkg::REG_COUPLING:    coupling = data;
				dmor_pkg::REG_DRIVE_AMP:   drive_amp = data;
				dmor_pkg::REG_TIME_SCALE:  time_scale = data[30:0];
				dmor_pkg::REG_GAMMA_MEAN:  gamma_mean = data;
				dmor_pkg::REG_GAMMA_SWING: gamma_swing = data;
				default: ;
			endcase
		endfunction

		// Round half up at bit n, then floor.
		function wv_t round_q(wv_t v, int n);
			return (v + (wv_t'(1) <<< (n - 1))) >>> n;
		endfunction

		function wv_t clamp32(wv_t v);
			if (v > S32_MAX) begin
				clip = 1;
				return S32_MAX;
			end
			if (v < S32_MIN) begin
				clip = 1;
				return S32_MIN;
			end
			return v;
		endfunction

		// Cosine and sine of a turn fraction, Q1.16, from the 16-step rotator.
		function void turn_cs(logic [15:0] ph, output wv_t co, output wv_t si);
			logic [31:0] a, b, t;
			bit flip;
			longint x, y, z, dx, dy;
			a = {ph, 16'h0};
			t = a + 32'h4000_0000;
			flip = t[31];
			b = flip ? a - 32'h8000_0000 : a;
			z = longint'($signed(b));
			x = 652032874;
			y = 0;
			for (int i = 0; i < 16; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx;
					y += dy;
					z -= longint'(dmor_pkg::ARC_TABLE[i]);
				end else begin
					x += dx;
					y -= dy;
					z += longint'(dmor_pkg::ARC_TABLE[i]);
				end
			end
			if (flip) begin
				x = -x;
				y = -y;
			end
			x = (x + 8192) >>> 14;
			y = (y + 8192) >>> 14;
			if (x > 65536) x = 65536;
			if (x < -65536) x = -65536;
			if (y > 65536) y = 65536;
			if (y < -65536) y = -65536;
			co = x;
			si = y;
		endfunction

		// Truncated num * 2^16 / den, saturated.
		function wv_t quot_q16(wv_t num, wv_t den);
			wv_t n, d, q;
			n = num < 0 ? -num : num;
			d = den < 0 ? -den : den;
			q = (n <<< 16) / d;
			return clamp32(((num < 0) != (den < 0)) ? -q : q);
		endfunction

		function void note_state(logic [15:0] tp, logic signed [31:0] p1_in,
				logic signed [31:0] p2_in, logic signed [31:0] m_in,
				logic [15:0] hp);
			wv_t ct, st, cg, sg, ch, sh, kc, mt, d, v1, v2, w, g, aa, jj, p1, p2;
			wv_t r [6];
			rates_t e;
			clip = 0;
			p1 = p1_in;
			p2 = p2_in;
			aa = wv_t'(inertia_a);
			jj = wv_t'(inertia_j);
			turn_cs(tp, ct, st);
			turn_cs(tp + dmor_pkg::PHASE_OFFSET, cg, sg);
			turn_cs(hp, ch, sh);
			kc = clamp32(round_q(wv_t'(coupling) * ct, 16));
			mt = clamp32(wv_t'(m_in) + round_q(wv_t'(drive_amp) * ct, 16));
			d = aa * jj - kc * kc;
			e.sing = (d == 0);
			if (e.sing) begin
				foreach (e.rate[i]) e.rate[i] = '0;
				e.sat = 0;
				pending.push_back(e);
				return;
			end
			v1 = quot_q16(jj * p1 - kc * mt, d);
			w = quot_q16(aa * mt - kc * p1, d);
			v2 = clamp32(round_q(p2 * wv_t'(inverse_b), 16));
			g = clamp32(wv_t'(gamma_mean) + round_q(wv_t'(gamma_swing) * sg, 16));
			r[0] = clamp32(round_q(p2 * w, 16) - round_q(g * v2, 16)
				- round_q(wv_t'(dmor_pkg::FRICTION_1) * v1, 16));
			r[1] = clamp32(-round_q(p1 * w, 16) + round_q(g * v1, 16)
				- round_q(wv_t'(dmor_pkg::FRICTION_2) * v2, 16));
			r[2] = clamp32(round_q(p1 * v2, 16) - round_q(p2 * v1, 16)
				- round_q(wv_t'(dmor_pkg::FRICTION_3) * w, 16));
			r[3] = clamp32(round_q(v1 * ch, 16) - round_q(v2 * sh, 16));
			r[4] = clamp32(round_q(v1 * sh, 16) + round_q(v2 * ch, 16));
			r[5] = w;
			for (int i = 0; i < 6; i++)
				e.rate[i] = 32'(clamp32(round_q(wv_t'(time_scale) * r[i], 16)));
			e.sat = clip;
			pending.push_back(e);
		endfunction

		function void check_word(logic [191:0] data, logic [1:0] user);
			rates_t e;
			string names [6] = '{"rate_momentum_1", "rate_momentum_2", "rate_moment",
				"rate_position_x", "rate_position_y", "rate_heading"};
			if (pending.size() == 0) begin
				$error("output word with no expected word pending");
				errors++;
				return;
			end
			e = pending.pop_front();
			for (int i = 0; i < 6; i++)
				if (data[32*i +: 32] !== e.rate[i]) begin
					$error("%s: expected %0d, got %0d", names[i],
						$signed(e.rate[i]), $signed(data[32*i +: 32]));
					errors++;
				end
			if (user[0] !== e.sing) begin
				$error("singular: expected %0b, got %0b", e.sing, user[0]);
				errors++;
			end
			if (user[1] !== e.sat) begin
				$error("saturated: expected %0b, got %0b", e.sat, user[1]);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [127:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [191:0] m_tdata;
	logic [1:0] m_tuser;

	rhs_scoreboard sb;
	bit idle_on = 1;
	bit hold_req = 0;

	double_mass_ode_rhs u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Outputs are stable at the falling edge; a word seen there is taken at the next rise.
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tdata, m_tuser);
	end

	// Receiver: random stall per word while idle_on is set, plus one long hold on request.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 0;
				m_tready <= 0;
				repeat (400) @(posedge clk);
			end
			gap = idle_on ? $urandom_range(0, 16) : 0;
			if (gap > 0) begin
				m_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1;
			do begin
				@(negedge clk);
			end while (!m_tvalid);
			@(posedge clk);
		end
	end

	// Drives one register write; the caller drops the write enable afterwards.
	task automatic write_reg(dmor_pkg::reg_idx_t idx, logic [31:0] data);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	task automatic write_all(logic [31:0] a, logic [31:0] ib, logic [31:0] j,
			logic [31:0] cpl, logic [31:0] drv, logic [31:0] ks,
			logic [31:0] gm, logic [31:0] gs);
		@(posedge clk);
		write_reg(dmor_pkg::REG_INERTIA_A, a);
		write_reg(dmor_pkg::REG_INVERSE_B, ib);
		write_reg(dmor_pkg::REG_INERTIA_J, j);
		write_reg(dmor_pkg::REG_COUPLING, cpl);
		write_reg(dmor_pkg::REG_DRIVE_AMP, drv);
		write_reg(dmor_pkg::REG_TIME_SCALE, ks);
		write_reg(dmor_pkg::REG_GAMMA_MEAN, gm);
		write_reg(dmor_pkg::REG_GAMMA_SWING, gs);
		cfg_we <= 0;
	endtask

	// Sends one state word and notes it once the handshake is seen.
	task automatic send_state(logic [15:0] tp, logic [31:0] p1, logic [31:0] p2,
			logic [31:0] m, logic [15:0] hp);
		int gap;
		gap = idle_on ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {hp, m, p2, p1, tp};
		do begin
			@(negedge clk);
		end while (!s_tready);
		sb.note_state(tp, p1, p2, m, hp);
		@(posedge clk);
	endtask

	task automatic wait_drained();
		int n;
		n = 0;
		s_tvalid <= 0;
		while (sb.pending.size() != 0 && n < 200000) begin
			@(posedge clk);
			n++;
		end
		repeat (60) @(posedge clk);
	endtask

	function automatic logic [31:0] pick32();
		case ($urandom_range(0, 6))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3: return $urandom_range(0, 1) ? $urandom_range(0, 1 << 20)
				: -$urandom_range(0, 1 << 20);
			4: return $urandom_range(0, 1) ? $urandom_range(0, 1 << 24)
				: -$urandom_range(0, 1 << 24);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_phase();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'(16'h4000 * $urandom_range(0, 3));
			default: return 16'($urandom);
		endcase
	endfunction

	// Register values: the extremes, zero, fully random or moderate.
	function automatic logic [31:0] pick_reg();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3: return $urandom;
			default: return $urandom_range(1, 1 << 19);
		endcase
	endfunction

	initial begin
		sb = new();
		sb.restore();
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed words at reset settings: field extremes and quadrant phases.
		send_state(16'h0000, 32'h0, 32'h0, 32'h0, 16'h0000);
		send_state(16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
		send_state(16'h4000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h4000);
		send_state(16'h8000, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 16'h8000);
		send_state(16'hC000, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 16'hC000);
		send_state(16'h2000, 32'h0010_0000, 32'h0020_0000, 32'hFFF0_0000, 16'h6000);
		send_state(16'h1234, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'hA000);
		wait_drained();

		// Singular denominator: K squared equals A times J when cos is +1 or -1.
		write_all(32'd65536, 32'd65536, 32'd65536, 32'd65536, 32'd0, 32'd411775,
			32'd0, 32'd0);
		send_state(16'h0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 16'h0000);
		send_state(16'h8000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
		send_state(16'h4000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 16'h1000);
		wait_drained();

		// Zero unsigned registers with the most negative signed ones, then the largest registers.
		write_all(32'd0, 32'd0, 32'd0, 32'h8000_0000, 32'h8000_0000, 32'd0,
			32'h8000_0000, 32'h8000_0000);
		send_state(16'h4000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 16'h2000);
		send_state(16'h0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0000);
		wait_drained();
		write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_state(16'h0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h4000);
		send_state(16'h2000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 16'hE000);
		wait_drained();

		// Random phases, each under its own register setting.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: write_all(32'd131072, 32'd32768, 32'd196608, 32'd19661, 32'd40000,
					32'd411775, 32'd65536, 32'd32768);
				1: write_all(32'd1, 32'd1, 32'd1, 32'd0, 32'd1, 32'd1, 32'd0, 32'd1);
				2: write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
					32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
				default: write_all(pick_reg(), pick_reg(), pick_reg(), pick_reg(),
					pick_reg(), pick_reg(), pick_reg(), pick_reg());
			endcase
			idle_on = (ph % 3) != 1;
			if (ph == 3)
				hold_req = 1;
			for (int k = 0; k < 190; k++)
				send_state(pick_phase(), pick32(), pick32(), pick32(), pick_phase());
			wait_drained();
			idle_on = 1;
		end

		if (sb.pending.size() != 0) begin
			$error("%0d expected words never arrived", sb.pending.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> filelist.f
hdl/dmor_pkg.sv
hdl/double_mass_ode_rhs.sv
tb/double_mass_ode_rhs_tb.sv
